[src/quoted_numeral_byte_parser_macros.svh]
// Assertion macros shared by the quoted numeral byte parser RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef QUOTED_NUMERAL_BYTE_PARSER_MACROS_SVH
`define QUOTED_NUMERAL_BYTE_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define QNBP_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define QNBP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/qnbp_pkg.sv]
// Package for the quoted numeral byte parser: item types, parser state, codes.
// No dependencies.
package qnbp_pkg;

  localparam logic [7:0] QUOTE_CHAR = 8'h27;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_X = 8'h78;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [4:0] NO_DIGIT   = 5'd16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_HEXPFX = 3'd3,
    PH_DEC    = 3'd4,
    PH_OCT    = 3'd5,
    PH_HEX    = 3'd6
  } phase_e;

  typedef struct packed {
    logic        literal_mode;
    phase_e      phase;
    logic        negative_sign;
    logic [63:0] accumulator;
    logic        overflowed;
    logic        error_seen;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    literal_mode:  1'b0,
    phase:         PH_IDLE,
    negative_sign: 1'b0,
    accumulator:   64'd0,
    overflowed:    1'b0,
    error_seen:    1'b0
  };

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       done_res;
    logic       parse_error;
  } out_item_t;

  // Digit value in base 16, or NO_DIGIT for anything else.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

[src/quoted_numeral_byte_parser.sv]
// Top level of the quoted numeral byte parser: input register, parse step, result register.
// Depends on qnbp_pkg, qnbp_step and quoted_numeral_byte_parser_macros.svh.
//
// Takes one character per item and produces at most one byte result per item;
// the end item always gives one result marked done, carrying the error flag.
// Throughput is one item per cycle while results are taken. An item accepted
// at one edge is parsed from the input register in the next cycle; its
// result is captured in the result register and offered on the output. The
// per-character step is one pass through the parse logic, whose longest path
// is the 68-bit multiply-by-ten-and-add of a decimal digit. An item waiting in
// the input register, even one that yields nothing, is held while an untaken
// result sits in the result register; ready drops only while both registers
// are occupied and the result is not taken.
`include "quoted_numeral_byte_parser_macros.svh"

module quoted_numeral_byte_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qnbp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qnbp_pkg::out_item_t out_item_o
);

  logic                   in_valid_q;
  qnbp_pkg::in_item_t     in_q;
  qnbp_pkg::parse_state_t st_q, st_d;
  logic                   out_valid_q;
  qnbp_pkg::out_item_t    out_q;
  logic                   res_valid;
  qnbp_pkg::out_item_t    res;
  logic                   advance;
  logic                   fire;

  // Advance when the result register is free or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  qnbp_step u_step (
    .st_i        (st_q),
    .item_i      (in_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Control state and parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= qnbp_pkg::STATE_RESET;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q && res_valid;
      if (fire) st_q <= st_d;
    end
  end

  // Payload registers: capture the item and hold the result.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_item_i;
    if (fire && res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `QNBP_ASSERT_NEXT(a_err_sticky, st_q.error_seen && !(fire && in_q.end_of_text),
                    st_q.error_seen, "error flag cleared without an end item")
  `QNBP_ASSERT_NEXT(a_end_resets, fire && in_q.end_of_text,
                    !st_q.error_seen && !st_q.literal_mode && st_q.phase == qnbp_pkg::PH_IDLE,
                    "parser state not reset after end item")
  `QNBP_ASSERT_NEXT(a_err_silent, fire && st_q.error_seen && !in_q.end_of_text,
                    !out_valid_q, "result produced while error is set")
  `QNBP_ASSERT(a_err_on_done, out_valid_q && out_q.parse_error,
               out_q.done_res && !out_q.byte_valid, "error reported off the done result")

endmodule

[src/qnbp_step.sv]
// Per-character parse step: next parser state and the optional result item.
// Pure combinational; uses qnbp_pkg.
module qnbp_step (
  input  qnbp_pkg::parse_state_t st_i,
  input  qnbp_pkg::in_item_t     item_i,
  output qnbp_pkg::parse_state_t st_o,
  output logic                   res_valid_o,
  output qnbp_pkg::out_item_t    res_o
);

  logic [7:0]  ch;
  logic [4:0]  dig;
  logic [67:0] dec_wide;
  logic [63:0] acc_dec, acc_oct, acc_hex;
  logic        ovf_dec, ovf_oct, ovf_hex;
  logic        end_num;
  logic [7:0]  num_byte;

  // Drop any pending numeral.
  function automatic qnbp_pkg::parse_state_t clear_num(input qnbp_pkg::parse_state_t s);
    qnbp_pkg::parse_state_t r;
    r               = s;
    r.phase         = qnbp_pkg::PH_IDLE;
    r.negative_sign = 1'b0;
    r.accumulator   = 64'd0;
    r.overflowed    = 1'b0;
    return r;
  endfunction

  // Handle a character with no numeral pending (numeral already cleared).
  function automatic qnbp_pkg::parse_state_t idle_char(input qnbp_pkg::parse_state_t s,
                                                       input logic [7:0] c);
    qnbp_pkg::parse_state_t r;
    r = s;
    if (c == qnbp_pkg::QUOTE_CHAR) begin
      r.literal_mode = 1'b1;
    end else if (c == qnbp_pkg::CHAR_SPACE ||
                 (c >= qnbp_pkg::CHAR_TAB && c <= qnbp_pkg::CHAR_CR)) begin
      r = s;
    end else if (c == qnbp_pkg::CHAR_PLUS || c == qnbp_pkg::CHAR_MINUS) begin
      r.negative_sign = (c == qnbp_pkg::CHAR_MINUS);
      r.phase         = qnbp_pkg::PH_SIGN;
    end else if (c == qnbp_pkg::CHAR_ZERO) begin
      r.phase = qnbp_pkg::PH_ZERO;
    end else if (c > qnbp_pkg::CHAR_ZERO && c <= qnbp_pkg::CHAR_NINE) begin
      r.accumulator = {56'd0, c - qnbp_pkg::CHAR_ZERO};
      r.phase       = qnbp_pkg::PH_DEC;
    end else begin
      r.error_seen = 1'b1;
    end
    return r;
  endfunction

  assign ch  = item_i.char_in;
  assign dig = qnbp_pkg::digit_of(ch);

  // Multiply-accumulate candidates for the three bases; overflow past 64 bits.
  assign dec_wide = ({4'd0, st_i.accumulator} << 3) + ({4'd0, st_i.accumulator} << 1)
                  + {63'd0, dig};
  assign ovf_dec  = |dec_wide[67:64];
  assign acc_dec  = dec_wide[63:0];
  assign ovf_oct  = |st_i.accumulator[63:61];
  assign acc_oct  = {st_i.accumulator[60:0], dig[2:0]};
  assign ovf_hex  = |st_i.accumulator[63:60];
  assign acc_hex  = {st_i.accumulator[59:0], dig[3:0]};

  // Low byte of the pending numeral; saturate on overflow, negate on minus.
  assign num_byte = st_i.overflowed    ? 8'hFF :
                    st_i.negative_sign ? 8'(8'd0 - st_i.accumulator[7:0]) :
                                         st_i.accumulator[7:0];

  // Next state and result.
  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    end_num     = 1'b0;
    if (item_i.end_of_text) begin
      res_valid_o    = 1'b1;
      res_o.done_res = 1'b1;
      if (!st_i.error_seen) begin
        case (st_i.phase)
          qnbp_pkg::PH_SIGN, qnbp_pkg::PH_HEXPFX: begin
            res_o.parse_error = 1'b1;
          end
          qnbp_pkg::PH_ZERO, qnbp_pkg::PH_DEC, qnbp_pkg::PH_OCT, qnbp_pkg::PH_HEX: begin
            res_o.byte_out   = num_byte;
            res_o.byte_valid = 1'b1;
          end
          default: begin
            res_o.byte_valid = 1'b0;
          end
        endcase
      end else begin
        res_o.parse_error = 1'b1;
      end
      st_o = qnbp_pkg::STATE_RESET;
    end else if (st_i.error_seen) begin
      st_o = st_i;
    end else if (st_i.literal_mode) begin
      if (ch == qnbp_pkg::QUOTE_CHAR) begin
        st_o.literal_mode = 1'b0;
      end else begin
        res_valid_o      = 1'b1;
        res_o.byte_out   = ch;
        res_o.byte_valid = 1'b1;
      end
    end else begin
      case (st_i.phase)
        qnbp_pkg::PH_SIGN: begin
          if (ch == qnbp_pkg::CHAR_ZERO) begin
            st_o.phase = qnbp_pkg::PH_ZERO;
          end else if (dig < 5'd10) begin
            st_o.accumulator = {59'd0, dig};
            st_o.phase       = qnbp_pkg::PH_DEC;
          end else begin
            st_o            = clear_num(st_i);
            st_o.error_seen = 1'b1;
          end
        end
        qnbp_pkg::PH_HEXPFX: begin
          if (dig != qnbp_pkg::NO_DIGIT) begin
            st_o.accumulator = {59'd0, dig};
            st_o.phase       = qnbp_pkg::PH_HEX;
          end else begin
            st_o            = clear_num(st_i);
            st_o.error_seen = 1'b1;
          end
        end
        qnbp_pkg::PH_ZERO: begin
          if (ch == qnbp_pkg::CHAR_LOW_X || ch == qnbp_pkg::CHAR_UP_X) begin
            st_o.phase = qnbp_pkg::PH_HEXPFX;
          end else if (dig < 5'd8) begin
            st_o.accumulator = {59'd0, dig};
            st_o.phase       = qnbp_pkg::PH_OCT;
          end else begin
            end_num = 1'b1;
          end
        end
        qnbp_pkg::PH_DEC: begin
          if (dig < 5'd10) begin
            if (!st_i.overflowed) begin
              if (ovf_dec) st_o.overflowed = 1'b1;
              else st_o.accumulator = acc_dec;
            end
          end else begin
            end_num = 1'b1;
          end
        end
        qnbp_pkg::PH_OCT: begin
          if (dig < 5'd8) begin
            if (!st_i.overflowed) begin
              if (ovf_oct) st_o.overflowed = 1'b1;
              else st_o.accumulator = acc_oct;
            end
          end else begin
            end_num = 1'b1;
          end
        end
        qnbp_pkg::PH_HEX: begin
          if (dig != qnbp_pkg::NO_DIGIT) begin
            if (!st_i.overflowed) begin
              if (ovf_hex) st_o.overflowed = 1'b1;
              else st_o.accumulator = acc_hex;
            end
          end else begin
            end_num = 1'b1;
          end
        end
        default: begin
          st_o = idle_char(clear_num(st_i), ch);
        end
      endcase
      // Emit the finished numeral, then treat the character afresh.
      if (end_num) begin
        res_valid_o      = 1'b1;
        res_o.byte_out   = num_byte;
        res_o.byte_valid = 1'b1;
        st_o             = idle_char(clear_num(st_i), ch);
      end
    end
  end

endmodule
